// ----- src/bptc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared widths, constants and register indexes for the barometric
// pressure and temperature compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

    // Field and register widths.
    localparam int CAL_W    = 16;
    localparam int RAW_W    = 24;
    localparam int TEMP_W   = 16;
    localparam int PRES_W   = 17;
    localparam int CFG_IDX_W = 3;

    // Number of pipeline stages, including the output register.
    localparam int NUM_STAGES = 9;

    // Calibration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESSURE_SENSITIVITY = 3'd0,
        REG_PRESSURE_OFFSET      = 3'd1,
        REG_SENS_TEMP_COEF       = 3'd2,
        REG_OFFSET_TEMP_COEF     = 3'd3,
        REG_REFERENCE_TEMP       = 3'd4,
        REG_TEMP_COEFFICIENT     = 3'd5
    } cal_index_t;

    // Temperature thresholds, written relative to 20.00 C.
    localparam logic signed [20:0] TEMP_REF      = 21'sd2000;
    localparam logic signed [19:0] LOW_DELTA     = -20'sd3500;
    localparam logic signed [20:0] LOW_OFFSET    = 21'sd3500;
    localparam logic signed [22:0] KELVIN_OFFSET = 23'sd27315;

    // Output saturation bounds.
    localparam logic signed [22:0] TEMP_CK_MIN = 23'sd23315;
    localparam logic signed [22:0] TEMP_CK_MAX = 23'sd35815;
    localparam logic signed [29:0] PRES_MIN    = 30'sd1000;
    localparam logic signed [29:0] PRES_MAX    = 30'sd120000;

endpackage

// ----- src/baro_pressure_temp_compensation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Second-order compensation of raw barometer readings into centikelvin and
// pascals, as a nine-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Load the six calibration words through cfg_we / cfg_index / cfg_data
//   while the block is idle; a write to an index above 5 is ignored.
//   Each request on the input channel (in_valid / in_ready) carries one raw
//   pressure and one raw temperature reading. Each yields one result on the
//   output channel (out_valid / out_ready): the temperature in centikelvin,
//   the pressure in pascals and a flag set when either value was clamped.
//   One request can enter every cycle while the receiver keeps taking results;
//   the rate is set by the nine register stages, which each hold one request
//   and move on together with their valid bits.
//   When the receiver stalls, the final stage holds its result and empty
//   stages behind it still fill, so up to 9 requests are held before in_ready
//   drops. Nothing is dropped or repeated.
//   Reset clears all valid bits and sets every calibration word to zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation
    import bptc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Calibration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CAL_W-1:0]      cfg_data,
    // Input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [RAW_W-1:0]      pressure_raw,
    input  logic [RAW_W-1:0]      temperature_raw,
    // Output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TEMP_W-1:0]     temperature_centikelvin,
    output logic [PRES_W-1:0]     pressure_pascal,
    output logic                  out_of_range
);

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    logic [CAL_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    // Each word is written directly from the port; unused indexes do nothing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cal_index_t'(cfg_index))
                REG_PRESSURE_SENSITIVITY: c1_reg <= cfg_data;
                REG_PRESSURE_OFFSET:      c2_reg <= cfg_data;
                REG_SENS_TEMP_COEF:       c3_reg <= cfg_data;
                REG_OFFSET_TEMP_COEF:     c4_reg <= cfg_data;
                REG_REFERENCE_TEMP:       c5_reg <= cfg_data;
                REG_TEMP_COEFFICIENT:     c6_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    // Valid bits travel with the data.
    always_comb
    begin
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Stage 1: temperature difference dT = D2 - C5 * 256
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]   s1_d1_reg;
    logic signed [25:0] s1_dt_reg;
    logic signed [25:0] s1_dt_next;

    assign s1_dt_next = $signed({2'b00, temperature_raw}) - $signed({2'b00, c5_reg, 8'h00});

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_d1_reg <= pressure_raw;
            s1_dt_reg <= s1_dt_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the four products of dT
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]   s2_d1_reg;
    logic signed [42:0] s2_mt_reg, s2_m4_reg, s2_m3_reg;
    logic signed [51:0] s2_dd_reg;
    logic signed [42:0] s2_mt_next, s2_m4_next, s2_m3_next;
    logic signed [51:0] s2_dd_next;

    assign s2_mt_next = s1_dt_reg * $signed({1'b0, c6_reg});
    assign s2_m4_next = s1_dt_reg * $signed({1'b0, c4_reg});
    assign s2_m3_next = s1_dt_reg * $signed({1'b0, c3_reg});
    assign s2_dd_next = s1_dt_reg * s1_dt_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_d1_reg <= s1_d1_reg;
            s2_mt_reg <= s2_mt_next;
            s2_m4_reg <= s2_m4_next;
            s2_m3_reg <= s2_m3_next;
            s2_dd_reg <= s2_dd_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: first-order temperature, region flags, linear OFF and SENS
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]   s3_d1_reg;
    logic signed [19:0] s3_a_reg;
    logic signed [20:0] s3_b_reg;
    logic signed [20:0] s3_temp_reg;
    logic [20:0]        s3_t2_reg;
    logic               s3_low_reg, s3_vlow_reg;
    logic signed [43:0] s3_off_lin_reg, s3_sens_lin_reg;
    logic signed [19:0] s3_a_next;
    logic signed [20:0] s3_b_next;
    logic signed [20:0] s3_temp_next;
    logic signed [43:0] s3_off_lin_next, s3_sens_lin_next;

    // The floor shift by 23 is the upper slice of the product.
    assign s3_a_next    = $signed(s2_mt_reg[42:23]);
    assign s3_temp_next = 21'(s3_a_next) + TEMP_REF;
    assign s3_b_next    = 21'(s3_a_next) + LOW_OFFSET;

    assign s3_off_lin_next  = $signed({12'h000, c2_reg, 16'h0000})
                            + 44'($signed(s2_m4_reg[42:7]));
    assign s3_sens_lin_next = $signed({13'h0000, c1_reg, 15'h0000})
                            + 44'($signed(s2_m3_reg[42:8]));

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_d1_reg       <= s2_d1_reg;
            s3_a_reg        <= s3_a_next;
            s3_b_reg        <= s3_b_next;
            s3_temp_reg     <= s3_temp_next;
            s3_t2_reg       <= s2_dd_reg[51:31];
            s3_low_reg      <= s3_a_next[19];
            s3_vlow_reg     <= (s3_a_next < LOW_DELTA);
            s3_off_lin_reg  <= s3_off_lin_next;
            s3_sens_lin_reg <= s3_sens_lin_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squares of the distances below the two thresholds
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]   s4_d1_reg;
    logic [39:0]        s4_aa_reg;
    logic [41:0]        s4_bb_reg;
    logic signed [20:0] s4_temp_reg;
    logic [20:0]        s4_t2_reg;
    logic               s4_low_reg, s4_vlow_reg;
    logic signed [43:0] s4_off_lin_reg, s4_sens_lin_reg;
    logic [39:0]        s4_aa_next;
    logic [41:0]        s4_bb_next;

    assign s4_aa_next = s3_a_reg * s3_a_reg;
    assign s4_bb_next = s3_b_reg * s3_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_d1_reg       <= s3_d1_reg;
            s4_aa_reg       <= s4_aa_next;
            s4_bb_reg       <= s4_bb_next;
            s4_temp_reg     <= s3_temp_reg;
            s4_t2_reg       <= s3_t2_reg;
            s4_low_reg      <= s3_low_reg;
            s4_vlow_reg     <= s3_vlow_reg;
            s4_off_lin_reg  <= s3_off_lin_reg;
            s4_sens_lin_reg <= s3_sens_lin_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: second-order terms and the corrected temperature
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]   s5_d1_reg;
    logic [43:0]        s5_off2_reg, s5_sens2_reg;
    logic signed [22:0] s5_temp_reg;
    logic signed [43:0] s5_off_lin_reg, s5_sens_lin_reg;
    logic [43:0]        aa5, bb7, bb11;
    logic [43:0]        s5_off2_next, s5_sens2_next;
    logic signed [22:0] s5_temp_next;

    // Both squares are non-negative, so plain shifts give the floor.
    assign aa5  = (44'(s4_aa_reg) << 2) + 44'(s4_aa_reg);
    assign bb7  = (44'(s4_bb_reg) << 3) - 44'(s4_bb_reg);
    assign bb11 = (44'(s4_bb_reg) << 3) + (44'(s4_bb_reg) << 1) + 44'(s4_bb_reg);

    always_comb
    begin
        s5_off2_next  = '0;
        s5_sens2_next = '0;
        if (s4_low_reg)
        begin
            s5_off2_next  = (aa5 >> 1) + (s4_vlow_reg ? bb7 : 44'd0);
            s5_sens2_next = (aa5 >> 2) + (s4_vlow_reg ? (bb11 >> 1) : 44'd0);
        end
    end

    assign s5_temp_next = 23'(s4_temp_reg)
                        - (s4_low_reg ? $signed({2'b00, s4_t2_reg}) : 23'sd0)
                        + KELVIN_OFFSET;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_d1_reg       <= s4_d1_reg;
            s5_off2_reg     <= s5_off2_next;
            s5_sens2_reg    <= s5_sens2_next;
            s5_temp_reg     <= s5_temp_next;
            s5_off_lin_reg  <= s4_off_lin_reg;
            s5_sens_lin_reg <= s4_sens_lin_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: final OFF and SENS, temperature saturation
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]   s6_d1_reg;
    logic signed [43:0] s6_off_reg;
    logic signed [39:0] s6_sens_reg;
    logic [TEMP_W-1:0]  s6_temp_reg;
    logic               s6_sat_reg;
    logic signed [43:0] s6_off_next, s6_sens_next;
    logic [TEMP_W-1:0]  s6_temp_next;
    logic               s6_sat_next;

    assign s6_off_next  = s5_off_lin_reg - $signed(s5_off2_reg);
    assign s6_sens_next = s5_sens_lin_reg - $signed(s5_sens2_reg);

    always_comb
    begin
        s6_sat_next  = 1'b0;
        s6_temp_next = s5_temp_reg[TEMP_W-1:0];
        if (s5_temp_reg < TEMP_CK_MIN)
        begin
            s6_sat_next  = 1'b1;
            s6_temp_next = TEMP_CK_MIN[TEMP_W-1:0];
        end
        else if (s5_temp_reg > TEMP_CK_MAX)
        begin
            s6_sat_next  = 1'b1;
            s6_temp_next = TEMP_CK_MAX[TEMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s6_d1_reg   <= s5_d1_reg;
            s6_off_reg  <= s6_off_next;
            s6_sens_reg <= s6_sens_next[39:0];
            s6_temp_reg <= s6_temp_next;
            s6_sat_reg  <= s6_sat_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: D1 * SENS as two partial products
    // ------------------------------------------------------------------
    logic [43:0]        s7_pl_reg;
    logic signed [44:0] s7_ph_reg;
    logic signed [43:0] s7_off_reg;
    logic [TEMP_W-1:0]  s7_temp_reg;
    logic               s7_sat_reg;
    logic [43:0]        s7_pl_next;
    logic signed [44:0] s7_ph_next;

    assign s7_pl_next = s6_d1_reg * s6_sens_reg[19:0];
    assign s7_ph_next = $signed({1'b0, s6_d1_reg}) * $signed(s6_sens_reg[39:20]);

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s7_pl_reg   <= s7_pl_next;
            s7_ph_reg   <= s7_ph_next;
            s7_off_reg  <= s6_off_reg;
            s7_temp_reg <= s6_temp_reg;
            s7_sat_reg  <= s6_sat_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: recombine the product, scale and take away OFF
    // ------------------------------------------------------------------
    logic signed [44:0] s8_q_reg;
    logic [TEMP_W-1:0]  s8_temp_reg;
    logic               s8_sat_reg;
    logic signed [64:0] s8_prod;
    logic signed [44:0] s8_q_next;

    assign s8_prod   = (65'(s7_ph_reg) <<< 20) + $signed({21'h000000, s7_pl_reg});
    assign s8_q_next = 45'($signed(s8_prod[64:21])) - 45'(s7_off_reg);

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s8_q_reg    <= s8_q_next;
            s8_temp_reg <= s7_temp_reg;
            s8_sat_reg  <= s7_sat_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: pressure scaling, saturation and the output register
    // ------------------------------------------------------------------
    logic [TEMP_W-1:0]  out_temp_reg;
    logic [PRES_W-1:0]  out_pres_reg;
    logic               out_flag_reg;
    logic signed [29:0] s9_p;
    logic [PRES_W-1:0]  s9_pres_next;
    logic               s9_sat_next;

    assign s9_p = $signed(s8_q_reg[44:15]);

    always_comb
    begin
        s9_sat_next  = s8_sat_reg;
        s9_pres_next = s9_p[PRES_W-1:0];
        if (s9_p < PRES_MIN)
        begin
            s9_sat_next  = 1'b1;
            s9_pres_next = PRES_MIN[PRES_W-1:0];
        end
        else if (s9_p > PRES_MAX)
        begin
            s9_sat_next  = 1'b1;
            s9_pres_next = PRES_MAX[PRES_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            out_temp_reg <= s8_temp_reg;
            out_pres_reg <= s9_pres_next;
            out_flag_reg <= s9_sat_next;
        end
    end

    assign temperature_centikelvin = out_temp_reg;
    assign pressure_pascal         = out_pres_reg;
    assign out_of_range            = out_flag_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Every delivered result lies inside both saturation ranges.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (temperature_centikelvin >= TEMP_CK_MIN[TEMP_W-1:0])
                   && (temperature_centikelvin <= TEMP_CK_MAX[TEMP_W-1:0])
                   && (pressure_pascal >= PRES_MIN[PRES_W-1:0])
                   && (pressure_pascal <= PRES_MAX[PRES_W-1:0]))
        else $error("result outside saturation range");

    // Input is refused only when every stage holds a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg))
        else $error("input refused while a stage is empty");

    // A request accepted into stage one shows up there in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0])
        else $error("accepted request lost at pipeline entry");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(pressure_pascal)
                                   && $stable(temperature_centikelvin))
        else $error("stalled result changed");

endmodule
